// File: src/assert_macros.svh
// assertion macros included by the scheduler rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/tts_pkg.sv
package tts_pkg;

   // table and time sizes
   localparam int SLOTS       = 16;
   localparam int TIME_BITS   = 16;
   localparam int MAX_RESULTS = 16;

   // fixed field widths
   localparam int ACTION_W  = 2;
   localparam int SLOT_F_W  = 4;
   localparam int ARG_W     = 16;
   localparam int KIND_W    = 3;
   localparam int STATUS_W  = 2;
   localparam int TIME_O_W  = 16;

   localparam logic [ARG_W-1:0] MODULUS_RESET = 16'd10000;

   // derived widths
   localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int IDX_W  = SLOT_W + 1;
   localparam int CNT_W  = $clog2(MAX_RESULTS + 1);
   localparam int MW     = TIME_BITS + 1;
   localparam int KW     = (TIME_BITS > 1) ? $clog2(TIME_BITS) : 1;
   localparam int XW     = MW + TIME_BITS;
   localparam int CW     = (MW > ARG_W + 1) ? MW : ARG_W + 1;
   localparam int ENTRY_W = 2 * TIME_BITS;

   typedef enum logic [ACTION_W-1:0] {
      ACT_TICK     = 2'd0,
      ACT_ADD      = 2'd1,
      ACT_DELETE   = 2'd2,
      ACT_DISPATCH = 2'd3
   } action_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_ADD    = 3'd0,
      KIND_DELETE = 3'd1,
      KIND_TICK   = 3'd2,
      KIND_FIRED  = 3'd3,
      KIND_NONE   = 3'd4
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2,
      ST_RANGE = 2'd3
   } status_type;

endpackage

// File: src/tts_req_if.sv
interface tts_req_if;
   import tts_pkg::*;

   logic                valid;
   logic                ready;
   action_type          action;
   logic [SLOT_F_W-1:0] slot;
   logic [ARG_W-1:0]    delay;
   logic [ARG_W-1:0]    period;

   modport source (output valid, action, slot, delay, period, input ready);
   modport sink   (input valid, action, slot, delay, period, output ready);
endinterface

// File: src/tts_rsp_if.sv
interface tts_rsp_if;
   import tts_pkg::*;

   logic                valid;
   logic                ready;
   kind_type            kind;
   status_type          status;
   logic [SLOT_F_W-1:0] task_slot;
   logic [TIME_O_W-1:0] current_time;
   logic                last;

   modport source (output valid, kind, status, task_slot, current_time, last, input ready);
   modport sink   (input valid, kind, status, task_slot, current_time, last, output ready);
endinterface

// File: src/tts_ram.sv
module tts_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                                         clock,
   input  logic                                         wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                             wr_data,
   input  logic                                         rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                             rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   // one write port, one registered read port; read data holds when idle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end
endmodule

// File: src/timeline_task_slot_scheduler.sv
// Sequence, from the accepting edge to the edge that loads the last result: tick and delete go
//   to S_FINISH; add runs 1 or TIME_BITS remainder steps (1 when time + delay < 2 * modulus).
// Dispatch: each slot scanned takes a read and an evaluate state, with 1 or TIME_BITS remainder
//   steps per periodic fire and a push per fire after the first; a full result register stalls.
// One item at a time; the next item can be taken in the cycle after the last result is loaded.
// Synchronous reset clears slot valid bits, time, modulus (to 10000) and all control.
`include "assert_macros.svh"

module timeline_task_slot_scheduler (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_wr_en,
   input  logic [tts_pkg::ARG_W-1:0] csr_wr_data,
   tts_req_if.sink                   req_chan,
   tts_rsp_if.source                 rsp_chan
);
   import tts_pkg::*;

   typedef enum logic [6:0] {
      S_IDLE    = 7'b0000001,
      S_ADD_MOD = 7'b0000010,
      S_SCAN_RD = 7'b0000100,
      S_SCAN_EV = 7'b0001000,
      S_PUSH    = 7'b0010000,
      S_DSP_MOD = 7'b0100000,
      S_FINISH  = 7'b1000000
   } state_type;

   state_type             state_ff, state_in;
   logic [TIME_BITS-1:0]  time_now_ff, time_now_in;
   logic [ARG_W-1:0]      modulus_ff, modulus_in;
   logic [SLOTS-1:0]      valid_ff, valid_in;
   logic [IDX_W-1:0]      idx_ff, idx_in;
   logic [TIME_BITS-1:0]  per_ff, per_in;
   kind_type              fin_kind_ff, fin_kind_in;
   status_type            fin_status_ff, fin_status_in;
   logic [SLOT_F_W-1:0]   fin_slot_ff, fin_slot_in;
   logic                  pend_valid_ff, pend_valid_in;
   logic [SLOT_W-1:0]     pend_slot_ff, pend_slot_in;
   logic [CNT_W-1:0]      fire_cnt_ff, fire_cnt_in;
   logic [MW-1:0]         mod_rem_ff, mod_rem_in;
   logic [KW-1:0]         mod_k_ff, mod_k_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   kind_type              rsp_kind_ff;
   status_type            rsp_status_ff;
   logic [SLOT_F_W-1:0]   rsp_slot_ff;
   logic [TIME_O_W-1:0]   rsp_time_ff;
   logic                  rsp_last_ff;

   // output register load
   logic                  out_free, out_load, out_last;
   kind_type              out_kind;
   status_type            out_status;
   logic [SLOT_F_W-1:0]   out_slot;

   // slot memory ports
   logic                  mem_we, mem_rd_en;
   logic [SLOT_W-1:0]     mem_addr;
   logic [ENTRY_W-1:0]    mem_wr_data, mem_rd_data;
   logic [TIME_BITS-1:0]  rd_due, rd_per;

   // effective modulus and arithmetic helpers
   logic [CW-1:0]         csr_w, top_w, m_w;
   logic [MW-1:0]         eff_m;
   logic [MW-1:0]         tick_sum, add_sum, dsp_sum;
   logic [TIME_BITS-1:0]  tick_next;
   logic [XW-1:0]         mod_shift, rem_ext;
   logic [MW-1:0]         rem_nxt;
   logic                  mod_done;
   logic                  req_fire, args_bad, slot_ok, scan_end, hit;
   logic                  free_found;
   logic [SLOT_W-1:0]     free_idx, del_idx, cur_idx;

   // state groups for the checks
   logic                  mod_state, scan_state;

   tts_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_addr),
      .rd_data (mem_rd_data)
   );

   assign rd_due = mem_rd_data[ENTRY_W-1:TIME_BITS];
   assign rd_per = mem_rd_data[TIME_BITS-1:0];

   // modulus clamped to 2 .. 2^TIME_BITS
   always_comb begin
      csr_w = CW'(modulus_ff);
      top_w = CW'(1) << TIME_BITS;
      if (csr_w < CW'(2)) begin
         m_w = CW'(2);
      end else if (csr_w > top_w) begin
         m_w = top_w;
      end else begin
         m_w = csr_w;
      end
      eff_m = m_w[MW-1:0];
   end

   // handshake and decode helpers
   assign req_fire = req_chan.valid && req_chan.ready;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign args_bad = (CW'(req_chan.delay) >= m_w) || (CW'(req_chan.period) >= m_w);
   assign slot_ok  = (32'(req_chan.slot) < SLOTS);
   assign del_idx  = SLOT_W'(req_chan.slot);
   assign cur_idx  = idx_ff[SLOT_W-1:0];
   assign scan_end = (idx_ff == IDX_W'(SLOTS)) || (fire_cnt_ff == CNT_W'(MAX_RESULTS));
   assign hit      = valid_ff[cur_idx] && (rd_due == time_now_ff);

   // time advance with wrap
   assign tick_sum  = MW'(time_now_ff) + MW'(1);
   assign tick_next = (tick_sum >= eff_m) ? '0 : tick_sum[TIME_BITS-1:0];
   assign add_sum   = MW'(time_now_ff) + MW'(TIME_BITS'(req_chan.delay));
   assign dsp_sum   = MW'(rd_due) + MW'(rd_per);

   // lowest free slot
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_found = 1'b1;
            free_idx   = SLOT_W'(i);
         end
      end
   end

   // remainder unit: one conditional subtract of modulus << k per cycle
   assign mod_shift = XW'(eff_m) << mod_k_ff;
   assign rem_ext   = XW'(mod_rem_ff);
   assign rem_nxt   = (rem_ext >= mod_shift) ? MW'(rem_ext - mod_shift) : mod_rem_ff;
   assign mod_done  = (mod_k_ff == '0);

   // sequencer
   always_comb begin
      state_in      = state_ff;
      time_now_in   = time_now_ff;
      modulus_in    = csr_wr_en ? csr_wr_data : modulus_ff;
      valid_in      = valid_ff;
      idx_in        = idx_ff;
      per_in        = per_ff;
      fin_kind_in   = fin_kind_ff;
      fin_status_in = fin_status_ff;
      fin_slot_in   = fin_slot_ff;
      pend_valid_in = pend_valid_ff;
      pend_slot_in  = pend_slot_ff;
      fire_cnt_in   = fire_cnt_ff;
      mod_rem_in    = mod_rem_ff;
      mod_k_in      = mod_k_ff;
      mem_we        = 1'b0;
      mem_rd_en     = 1'b0;
      mem_addr      = cur_idx;
      mem_wr_data   = {rem_nxt[TIME_BITS-1:0], per_ff};
      out_load      = 1'b0;
      out_kind      = fin_kind_ff;
      out_status    = fin_status_ff;
      out_slot      = fin_slot_ff;
      out_last      = 1'b1;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               unique case (req_chan.action)
                  ACT_TICK: begin
                     time_now_in   = tick_next;
                     fin_kind_in   = KIND_TICK;
                     fin_status_in = ST_OK;
                     fin_slot_in   = '0;
                     state_in      = S_FINISH;
                  end
                  ACT_ADD: begin
                     fin_kind_in = KIND_ADD;
                     fin_slot_in = '0;
                     priority if (args_bad) begin
                        fin_status_in = ST_RANGE;
                        state_in      = S_FINISH;
                     end else if (!free_found) begin
                        fin_status_in = ST_FULL;
                        state_in      = S_FINISH;
                     end else begin
                        valid_in[free_idx] = 1'b1;
                        idx_in     = IDX_W'(free_idx);
                        per_in     = TIME_BITS'(req_chan.period);
                        mod_rem_in = add_sum;
                        mod_k_in   = ({1'b0, add_sum} < {eff_m, 1'b0}) ?
                                     '0 : KW'(TIME_BITS - 1);
                        state_in   = S_ADD_MOD;
                     end
                  end
                  ACT_DELETE: begin
                     fin_kind_in = KIND_DELETE;
                     fin_slot_in = req_chan.slot;
                     if (!slot_ok) begin
                        fin_status_in = ST_RANGE;
                     end else begin
                        fin_status_in     = valid_ff[del_idx] ? ST_OK : ST_EMPTY;
                        valid_in[del_idx] = 1'b0;
                     end
                     state_in = S_FINISH;
                  end
                  ACT_DISPATCH: begin
                     idx_in        = '0;
                     fire_cnt_in   = '0;
                     pend_valid_in = 1'b0;
                     state_in      = S_SCAN_RD;
                  end
               endcase
            end
         end
         S_ADD_MOD: begin
            mod_rem_in = rem_nxt;
            mod_k_in   = mod_k_ff - KW'(1);
            if (mod_done) begin
               mem_we        = 1'b1;
               fin_status_in = ST_OK;
               fin_slot_in   = SLOT_F_W'(cur_idx);
               state_in      = S_FINISH;
            end
         end
         S_SCAN_RD: begin
            if (scan_end) begin
               fin_status_in = ST_OK;
               if (pend_valid_ff) begin
                  fin_kind_in = KIND_FIRED;
                  fin_slot_in = SLOT_F_W'(pend_slot_ff);
               end else begin
                  fin_kind_in = KIND_NONE;
                  fin_slot_in = '0;
               end
               pend_valid_in = 1'b0;
               state_in      = S_FINISH;
            end else begin
               mem_rd_en = 1'b1;
               state_in  = S_SCAN_EV;
            end
         end
         S_SCAN_EV: begin
            // read data holds while the earlier fire is pushed out
            priority if (!hit) begin
               idx_in   = idx_ff + IDX_W'(1);
               state_in = S_SCAN_RD;
            end else if (pend_valid_ff) begin
               state_in = S_PUSH;
            end else begin
               pend_valid_in = 1'b1;
               pend_slot_in  = cur_idx;
               fire_cnt_in   = fire_cnt_ff + CNT_W'(1);
               if (rd_per == '0) begin
                  valid_in[cur_idx] = 1'b0;
                  idx_in            = idx_ff + IDX_W'(1);
                  state_in          = S_SCAN_RD;
               end else begin
                  mod_rem_in = dsp_sum;
                  mod_k_in   = ({1'b0, dsp_sum} < {eff_m, 1'b0}) ?
                               '0 : KW'(TIME_BITS - 1);
                  state_in   = S_DSP_MOD;
               end
            end
         end
         S_PUSH: begin
            if (out_free) begin
               out_load      = 1'b1;
               out_kind      = KIND_FIRED;
               out_status    = ST_OK;
               out_slot      = SLOT_F_W'(pend_slot_ff);
               out_last      = 1'b0;
               pend_valid_in = 1'b0;
               state_in      = S_SCAN_EV;
            end
         end
         S_DSP_MOD: begin
            mod_rem_in  = rem_nxt;
            mod_k_in    = mod_k_ff - KW'(1);
            mem_wr_data = {rem_nxt[TIME_BITS-1:0], rd_per};
            if (mod_done) begin
               mem_we   = 1'b1;
               idx_in   = idx_ff + IDX_W'(1);
               state_in = S_SCAN_RD;
            end
         end
         S_FINISH: begin
            if (out_free) begin
               out_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = out_load || (rsp_valid_ff && !rsp_chan.ready);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         time_now_ff   <= '0;
         modulus_ff    <= MODULUS_RESET;
         valid_ff      <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         fire_cnt_ff   <= '0;
      end else begin
         state_ff      <= state_in;
         time_now_ff   <= time_now_in;
         modulus_ff    <= modulus_in;
         valid_ff      <= valid_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         fire_cnt_ff   <= fire_cnt_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      per_ff        <= per_in;
      fin_kind_ff   <= fin_kind_in;
      fin_status_ff <= fin_status_in;
      fin_slot_ff   <= fin_slot_in;
      pend_slot_ff  <= pend_slot_in;
      mod_rem_ff    <= mod_rem_in;
      mod_k_ff      <= mod_k_in;
      if (out_load) begin
         rsp_kind_ff   <= out_kind;
         rsp_status_ff <= out_status;
         rsp_slot_ff   <= out_slot;
         rsp_time_ff   <= TIME_O_W'(time_now_ff);
         rsp_last_ff   <= out_last;
      end
   end

   // channel hookup
   assign req_chan.ready        = (state_ff == S_IDLE);
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.kind         = rsp_kind_ff;
   assign rsp_chan.status       = rsp_status_ff;
   assign rsp_chan.task_slot    = rsp_slot_ff;
   assign rsp_chan.current_time = rsp_time_ff;
   assign rsp_chan.last         = rsp_last_ff;

   // state groups
   assign mod_state  = (state_ff == S_ADD_MOD) || (state_ff == S_DSP_MOD);
   assign scan_state = (state_ff == S_SCAN_RD) || (state_ff == S_SCAN_EV) ||
                       (state_ff == S_PUSH)    || (state_ff == S_DSP_MOD);

   // checks
   `ASSERT_IMPLY(a_no_overwrite, clock, reset, out_load, out_free, "result register overwritten")
   `ASSERT_ALWAYS(a_fire_cap, clock, reset, fire_cnt_ff <= CNT_W'(MAX_RESULTS), "fire cap exceeded")
   `ASSERT_IMPLY(a_write_end, clock, reset, mem_we, mod_done && mod_state, "write outside remainder")
   `ASSERT_IMPLY(a_pend_scan, clock, reset, pend_valid_ff, scan_state, "pending fire outside scan")
   `ASSERT_NEXT(a_item_busy, clock, reset, req_fire, state_ff != S_IDLE, "accepted item left no work")

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import tts_pkg::*;

   localparam int CYCLE_LIMIT     = 1000000;
   localparam int RESET_CYCLES    = 12;
   localparam int DRAIN_CYCLES    = 40;
   localparam int ITEMS_PER_PHASE = 19;

   typedef struct {
      action_type          action;
      logic [SLOT_F_W-1:0] slot;
      logic [ARG_W-1:0]    delay;
      logic [ARG_W-1:0]    period;
   } sched_request_type;

   typedef struct {
      kind_type            kind;
      status_type          status;
      logic [SLOT_F_W-1:0] task_slot;
      logic [TIME_O_W-1:0] current_time;
      logic                last;
   } sched_result_type;

   // shadow task table and the results it predicts
   class sched_scoreboard;
      bit                  slot_used [SLOTS];
      logic [ARG_W-1:0]    due_at    [SLOTS];
      logic [ARG_W-1:0]    reload    [SLOTS];
      logic [TIME_O_W-1:0] cur_time;
      logic [ARG_W-1:0]    modulus_reg;
      sched_result_type    expected_results [$];
      int                  errors;
      int                  checked;
      int                  firings;

      function new();
         errors  = 0;
         checked = 0;
         firings = 0;
         foreach (slot_used[i]) slot_used[i] = 1'b0;
         cur_time    = '0;
         modulus_reg = MODULUS_RESET;
      endfunction

      // register values below two behave as two
      function int unsigned active_modulus();
         return (modulus_reg < 2) ? 2 : int'(modulus_reg);
      endfunction

      function void set_modulus(logic [ARG_W-1:0] value);
         modulus_reg = value;
      endfunction

      function void push_result(kind_type kind, status_type status,
                                logic [SLOT_F_W-1:0] task_slot, logic last);
         sched_result_type r;
         r.kind         = kind;
         r.status       = status;
         r.task_slot    = task_slot;
         r.current_time = cur_time;
         r.last         = last;
         expected_results.push_back(r);
      endfunction

      function void note_request(sched_request_type req);
         int unsigned m;
         int unsigned next_time;
         int          free_idx;
         int          i;
         int          hit_slot [$];
         m = active_modulus();
         case (req.action)
            ACT_TICK: begin
               // time left above a lowered modulus wraps to zero too
               next_time = cur_time + 1;
               cur_time  = (next_time >= m) ? '0 : next_time[TIME_O_W-1:0];
               push_result(KIND_TICK, ST_OK, '0, 1'b1);
            end
            ACT_ADD: begin
               if (req.delay >= m || req.period >= m) begin
                  push_result(KIND_ADD, ST_RANGE, '0, 1'b1);
               end else begin
                  free_idx = -1;
                  for (i = 0; i < SLOTS; i++)
                     if (!slot_used[i] && free_idx < 0) free_idx = i;
                  if (free_idx < 0) begin
                     push_result(KIND_ADD, ST_FULL, '0, 1'b1);
                  end else begin
                     slot_used[free_idx] = 1'b1;
                     due_at[free_idx]    = ARG_W'((32'(cur_time) + 32'(req.delay)) % m);
                     reload[free_idx]    = req.period;
                     push_result(KIND_ADD, ST_OK, SLOT_F_W'(free_idx), 1'b1);
                  end
               end
            end
            ACT_DELETE: begin
               push_result(KIND_DELETE, slot_used[req.slot] ? ST_OK : ST_EMPTY,
                           req.slot, 1'b1);
               slot_used[req.slot] = 1'b0;
            end
            default: begin
               // scan in slot order, one-shot tasks leave after firing
               for (i = 0; i < SLOTS && hit_slot.size() < MAX_RESULTS; i++) begin
                  if (slot_used[i] && due_at[i] == cur_time) begin
                     if (reload[i] == 0) slot_used[i] = 1'b0;
                     else due_at[i] = ARG_W'((32'(due_at[i]) + 32'(reload[i])) % m);
                     hit_slot.push_back(i);
                  end
               end
               if (hit_slot.size() == 0) push_result(KIND_NONE, ST_OK, '0, 1'b1);
               foreach (hit_slot[k])
                  push_result(KIND_FIRED, ST_OK, SLOT_F_W'(hit_slot[k]),
                              k == hit_slot.size() - 1);
               firings += hit_slot.size();
            end
         endcase
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         end
      endfunction

      function void check_result(sched_result_type got);
         sched_result_type want;
         checked++;
         if (expected_results.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, expected none, actual kind %0d slot %0d",
                     $time, got.kind, got.task_slot);
            return;
         end
         want = expected_results.pop_front();
         compare_field("kind", want.kind, got.kind);
         compare_field("status", want.status, got.status);
         compare_field("task_slot", want.task_slot, got.task_slot);
         compare_field("current_time", want.current_time, got.current_time);
         compare_field("last", want.last, got.last);
      endfunction
   endclass

   logic             clock;
   logic             reset;
   logic             csr_wr_en;
   logic [ARG_W-1:0] csr_wr_data;
   int               cycles = 0;
   int               requests_sent;
   bit               steady;
   int               phase_moduli [6];

   tts_req_if req_chan ();
   tts_rsp_if rsp_chan ();

   sched_scoreboard sb = new();

   timeline_task_slot_scheduler u_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan)
   );

   // clock
   initial clock = 1'b0;
   always #5 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles", $time, cycles);
         $display("** timeline_task_slot_scheduler: FAILED **");
         $finish;
      end
   end

   // mostly short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // result side back-pressure
   initial begin
      int on_len;
      int gap;
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         on_len = $urandom_range(1, 30);
         rsp_chan.ready <= 1'b1;
         repeat (on_len) @(posedge clock);
         gap = pick_gap();
         if (gap > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   end

   // result transfer check
   always @(posedge clock) begin
      sched_result_type got;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got.kind         = rsp_chan.kind;
         got.status       = rsp_chan.status;
         got.task_slot    = rsp_chan.task_slot;
         got.current_time = rsp_chan.current_time;
         got.last         = rsp_chan.last;
         sb.check_result(got);
      end
   end

   function automatic sched_request_type make_request(action_type action,
                                                      logic [SLOT_F_W-1:0] slot,
                                                      logic [ARG_W-1:0] delay,
                                                      logic [ARG_W-1:0] period);
      sched_request_type r;
      r.action = action;
      r.slot   = slot;
      r.delay  = delay;
      r.period = period;
      return r;
   endfunction

   // mostly firing-friendly adds, some out-of-range arguments
   function automatic sched_request_type random_request();
      sched_request_type r;
      int unsigned       m;
      int unsigned       cap;
      int                pick;
      int                sel;
      m      = sb.active_modulus();
      cap    = (m - 1 < 6) ? m - 1 : 6;
      r.slot   = SLOT_F_W'($urandom_range(0, SLOTS - 1));
      r.delay  = ARG_W'($urandom());
      r.period = ARG_W'($urandom());
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
         r.action = ACT_TICK;
      end else if (pick < 57) begin
         r.action = ACT_ADD;
         sel = $urandom_range(0, 99);
         if (sel < 70) r.delay = ARG_W'($urandom_range(0, cap));
         else if (sel < 85) r.delay = ARG_W'($urandom_range(0, m - 1));
         sel = $urandom_range(0, 99);
         if (sel < 30) r.period = '0;
         else if (sel < 80) r.period = ARG_W'($urandom_range(1, cap));
         else if (sel < 92) r.period = ARG_W'($urandom_range(0, m - 1));
      end else if (pick < 72) begin
         r.action = ACT_DELETE;
      end else begin
         r.action = ACT_DISPATCH;
      end
      return r;
   endfunction

   // one request transfer, entered and left at a rising edge
   task automatic send_request(sched_request_type item, int gap);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid  <= 1'b1;
      req_chan.action <= item.action;
      req_chan.slot   <= item.slot;
      req_chan.delay  <= item.delay;
      req_chan.period <= item.period;
      do @(posedge clock); while (!req_chan.ready);
      sb.note_request(item);
      requests_sent++;
   endtask

   // next gap, with stretches of back-to-back transfers
   function automatic int next_gap();
      if ($urandom_range(0, 14) == 0) steady = !steady;
      return steady ? 0 : pick_gap();
   endfunction

   task automatic run_directed();
      int i;
      send_request(make_request(ACT_ADD, 4'd0, 16'd0, 16'd0), next_gap());
      send_request(make_request(ACT_DISPATCH, 4'd0, 16'd0, 16'd0), next_gap());
      send_request(make_request(ACT_DISPATCH, 4'hF, 16'hFFFF, 16'hFFFF), next_gap());
      // delay and period above, at and just below the modulus
      send_request(make_request(ACT_ADD, 4'd0, 16'hFFFF, 16'd0), next_gap());
      send_request(make_request(ACT_ADD, 4'd0, 16'd0, MODULUS_RESET), next_gap());
      send_request(make_request(ACT_ADD, 4'd0, MODULUS_RESET - 1, MODULUS_RESET - 1),
                   next_gap());
      send_request(make_request(ACT_DELETE, 4'd0, 16'd0, 16'd0), next_gap());
      send_request(make_request(ACT_DELETE, 4'hF, 16'd0, 16'd0), next_gap());
      send_request(make_request(ACT_TICK, 4'hF, 16'hFFFF, 16'hFFFF), next_gap());
      // fill the table, overflow it, then fire every slot at once
      for (i = 0; i < SLOTS; i++)
         send_request(make_request(ACT_ADD, 4'd0, 16'd0, 16'd1), next_gap());
      send_request(make_request(ACT_ADD, 4'd0, 16'd0, 16'd0), next_gap());
      send_request(make_request(ACT_DISPATCH, 4'd0, 16'd0, 16'd0), next_gap());
      send_request(make_request(ACT_TICK, 4'd0, 16'd0, 16'd0), next_gap());
   endtask

   task automatic run_random(int count);
      repeat (count) send_request(random_request(), next_gap());
   endtask

   // block idle: all results in and the pipeline quiet
   task automatic settle();
      req_chan.valid <= 1'b0;
      while (sb.expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_modulus(logic [ARG_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      sb.set_modulus(value);
   endtask

   // main sequence
   initial begin
      requests_sent = 0;
      steady        = 1'b0;
      phase_moduli  = '{3, 0, 1, 65535, 12, 2};
      phase_moduli[5] = int'($urandom_range(2, 300));
      reset           <= 1'b1;
      csr_wr_en       <= 1'b0;
      csr_wr_data     <= '0;
      req_chan.valid  <= 1'b0;
      req_chan.action <= ACT_TICK;
      req_chan.slot   <= '0;
      req_chan.delay  <= '0;
      req_chan.period <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      run_directed();
      run_random(ITEMS_PER_PHASE);
      foreach (phase_moduli[p]) begin
         settle();
         write_modulus(ARG_W'(phase_moduli[p]));
         run_random(ITEMS_PER_PHASE);
      end
      settle();

      $display("covered %0d requests, %0d results checked, %0d task firings",
               requests_sent, sb.checked, sb.firings);
      $display("time moduli 10000, 3, 0, 1, 65535, 12 and %0d", phase_moduli[5]);
      if (sb.errors == 0) begin
         $display("** timeline_task_slot_scheduler: PASSED **");
      end else begin
         $display("%0d mismatches", sb.errors);
         $display("** timeline_task_slot_scheduler: FAILED **");
      end
      $finish;
   end

endmodule

// File: timeline_task_slot_scheduler.f
+incdir+src
src/tts_pkg.sv
src/tts_req_if.sv
src/tts_rsp_if.sv
src/tts_ram.sv
src/timeline_task_slot_scheduler.sv
dv/testbench.sv
